// ===== hw/rtl/pgsdf_pkg.sv =====
// shared types, codes and microcode program of the pwm gas sensor framer
package pgsdf_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;
   localparam int SCALE_W     = 14;
   localparam int PPM_W       = 16;
   localparam int QUOT_STEPS  = 17;
   localparam int STEP_CNT_W  = 5;
   localparam int PC_W        = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_FULL_SCALE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_EDGE_MARGIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEAD_BYTE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE_BYTE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE_MASK = 3'd4;

   localparam logic [2:0] COND_NEVER     = 3'd0;
   localparam logic [2:0] COND_NOFALL    = 3'd1;
   localparam logic [2:0] COND_DIVBUSY   = 3'd2;
   localparam logic [2:0] COND_NOESC_HI  = 3'd3;
   localparam logic [2:0] COND_NOESC_LO  = 3'd4;
   localparam logic [2:0] COND_ALWAYS    = 3'd5;

   localparam logic [2:0] SRC_HEAD  = 3'd0;
   localparam logic [2:0] SRC_ESC   = 3'd1;
   localparam logic [2:0] SRC_DATA  = 3'd2;
   localparam logic [2:0] SRC_XDATA = 3'd3;
   localparam logic [2:0] SRC_SUM   = 3'd4;

   localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
   localparam logic [PC_W-1:0] PC_MUL     = 4'd1;
   localparam logic [PC_W-1:0] PC_START   = 4'd2;
   localparam logic [PC_W-1:0] PC_WAIT    = 4'd3;
   localparam logic [PC_W-1:0] PC_PPM     = 4'd4;
   localparam logic [PC_W-1:0] PC_HEAD    = 4'd5;
   localparam logic [PC_W-1:0] PC_HI_CHK  = 4'd6;
   localparam logic [PC_W-1:0] PC_HI_ESC  = 4'd7;
   localparam logic [PC_W-1:0] PC_HI_XOR  = 4'd8;
   localparam logic [PC_W-1:0] PC_HI_RAW  = 4'd9;
   localparam logic [PC_W-1:0] PC_LO_CHK  = 4'd10;
   localparam logic [PC_W-1:0] PC_LO_ESC  = 4'd11;
   localparam logic [PC_W-1:0] PC_LO_XOR  = 4'd12;
   localparam logic [PC_W-1:0] PC_LO_RAW  = 4'd13;
   localparam logic [PC_W-1:0] PC_SUM     = 4'd14;

   typedef struct packed {
      logic [PC_W-1:0] target;
      logic [2:0]      cond;
      logic            in_ready;
      logic            calc;
      logic            div_start;
      logic            ppm_load;
      logic            emit;
      logic [2:0]      src;
      logic            byte_lo;
      logic            last;
   } ctrl_type;

   typedef struct packed {
      logic fall_acc;
      logic div_busy;
      logic esc_hi;
      logic esc_lo;
      logic out_free;
   } stat_type;

   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '0;
      w.cond = COND_NEVER;
      w.target = PC_IDLE;
      w.src = SRC_HEAD;
      unique case (pc)
         PC_IDLE: begin
            w.in_ready = 1'b1;
            w.cond = COND_NOFALL;
            w.target = PC_IDLE;
         end
         PC_MUL:   w.calc = 1'b1;
         PC_START: w.div_start = 1'b1;
         PC_WAIT: begin
            w.cond = COND_DIVBUSY;
            w.target = PC_WAIT;
         end
         PC_PPM:   w.ppm_load = 1'b1;
         PC_HEAD: begin
            w.emit = 1'b1;
            w.src = SRC_HEAD;
         end
         PC_HI_CHK: begin
            w.cond = COND_NOESC_HI;
            w.target = PC_HI_RAW;
         end
         PC_HI_ESC: begin
            w.emit = 1'b1;
            w.src = SRC_ESC;
         end
         PC_HI_XOR: begin
            w.emit = 1'b1;
            w.src = SRC_XDATA;
            w.cond = COND_ALWAYS;
            w.target = PC_LO_CHK;
         end
         PC_HI_RAW: begin
            w.emit = 1'b1;
            w.src = SRC_DATA;
         end
         PC_LO_CHK: begin
            w.cond = COND_NOESC_LO;
            w.target = PC_LO_RAW;
            w.byte_lo = 1'b1;
         end
         PC_LO_ESC: begin
            w.emit = 1'b1;
            w.src = SRC_ESC;
            w.byte_lo = 1'b1;
         end
         PC_LO_XOR: begin
            w.emit = 1'b1;
            w.src = SRC_XDATA;
            w.byte_lo = 1'b1;
            w.cond = COND_ALWAYS;
            w.target = PC_SUM;
         end
         PC_LO_RAW: begin
            w.emit = 1'b1;
            w.src = SRC_DATA;
            w.byte_lo = 1'b1;
         end
         PC_SUM: begin
            w.emit = 1'b1;
            w.src = SRC_SUM;
            w.last = 1'b1;
            w.cond = COND_ALWAYS;
            w.target = PC_IDLE;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/pgsdf_divider.sv =====
// iterative restoring divider with a saturated 16-bit quotient
module pgsdf_divider #(
   parameter int NUM_W = 46,
   parameter int DEN_W = 33
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [NUM_W-1:0]               num,
   input  logic [DEN_W-1:0]               den,
   output logic                           busy,
   output logic [pgsdf_pkg::PPM_W-1:0]    quot
);
   import pgsdf_pkg::*;

   localparam int CW = DEN_W + PPM_W;

   logic [CW-1:0]         rem_ff, rem_in;
   logic [CW-1:0]         div_ff, div_in;
   logic [QUOT_STEPS-1:0] q_ff, q_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  ge;

   assign ge   = rem_ff >= div_ff;
   assign busy = cnt_ff != '0;
   assign quot = q_ff[QUOT_STEPS-1] ? {PPM_W{1'b1}} : q_ff[PPM_W-1:0];

   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = CW'(num);
         div_in = {den, {PPM_W{1'b0}}};
         q_in   = '0;
         cnt_in = STEP_CNT_W'(QUOT_STEPS);
      end else if (busy) begin
         if (ge) begin
            rem_in = rem_ff - div_ff;
         end
         div_in = div_ff >> 1;
         q_in   = {q_ff[QUOT_STEPS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/pgsdf_seq.sv =====
// microcode sequencer: step counter, program table and conditional jumps
module pgsdf_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  pgsdf_pkg::stat_type  stat,
   output pgsdf_pkg::ctrl_type  ctrl
);
   import pgsdf_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            taken;

   assign ctrl = ucode(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:    taken = 1'b0;
         COND_NOFALL:   taken = !stat.fall_acc;
         COND_DIVBUSY:  taken = stat.div_busy;
         COND_NOESC_HI: taken = !stat.esc_hi;
         COND_NOESC_LO: taken = !stat.esc_lo;
         COND_ALWAYS:   taken = 1'b1;
         default:       taken = 1'b1;
      endcase
      if (ctrl.emit && !stat.out_free) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/pwm_gas_sensor_decode_framer_top.sv =====
// top level: pwm duty decoder, ppm datapath and byte-stuffed framer
//
// req_* takes one pin sample per transaction, one per millisecond tick; the
// transaction count is the time base. A falling edge starts a ppm update and
// a frame of four to six bytes on rsp_*: head, ppm high and low byte (each
// escaped when it equals the head or escape byte) and the checksum, which
// carries rsp_tlast. csr_* writes the five registers by index; writes are
// always taken.
// A sample with no falling edge is taken in the idle step. After a falling edge
// the head byte follows the multiply, divider start, 17 divider steps plus a
// done check in the restoring unit and the ppm update; each data
// byte follows an escape check step, and the next sample is taken once the
// checksum is loaded, so no new sample is taken while a frame is being built.
// A stalled receiver holds the output register and the program waits at
// the byte step; no sample is taken until the checksum is loaded.
// Reset clears the time base, edge times and output, loads the register
// defaults and sets ppm to 1000.
module pwm_gas_sensor_decode_framer_top #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [0] pin_level
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] frame_byte
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pgsdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pgsdf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pgsdf_pkg::*;

   localparam int TW    = TIME_WIDTH;
   localparam int PROD_W = TW + SCALE_W;
   localparam int DEN_W  = TW + 1;
   localparam int DENX_W = TW + 2;

   ctrl_type ctrl;
   stat_type stat;

   logic [SCALE_W-1:0] full_scale_ff;
   logic [7:0]         margin_ff, head_ff, esc_ff, mask_ff;

   logic [TW-1:0]     ms_ff, rise_ff, fall_ff, low_ff, high_ff;
   logic              prev_ff;
   logic [PPM_W-1:0]  ppm_ff, ppm_in;
   logic [PROD_W-1:0] prod_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              num_neg_ff, den_nonpos_ff;
   logic [7:0]        sum_ff;
   logic              out_valid_ff;
   logic [7:0]        out_byte_ff;
   logic              out_last_ff;

   logic              accept, level, out_free, fire;
   logic [TW:0]       num;
   logic [DENX_W-1:0] den;
   logic [PROD_W-1:0] prod;
   logic              div_busy;
   logic [PPM_W-1:0]  quot;
   logic [7:0]        data_byte, out_byte;

   assign csr_ready  = 1'b1;
   assign req_tready = ctrl.in_ready;
   assign accept     = req_tvalid && ctrl.in_ready;
   assign level      = req_tdata[0];
   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = ctrl.emit && out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   assign data_byte = ctrl.byte_lo ? ppm_ff[7:0] : ppm_ff[15:8];

   assign stat.fall_acc = accept && prev_ff && !level;
   assign stat.div_busy = div_busy;
   assign stat.esc_hi   = (ppm_ff[15:8] == esc_ff) || (ppm_ff[15:8] == head_ff);
   assign stat.esc_lo   = (ppm_ff[7:0] == esc_ff) || (ppm_ff[7:0] == head_ff);
   assign stat.out_free = out_free;

   assign num  = {1'b0, high_ff} - (TW + 1)'(margin_ff);
   assign den  = DENX_W'(high_ff) + DENX_W'(low_ff) - DENX_W'({margin_ff, 1'b0});
   assign prod = PROD_W'(full_scale_ff) * PROD_W'(num[TW-1:0]);

   pgsdf_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   pgsdf_divider #(
      .NUM_W (PROD_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .num   (prod_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quot  (quot)
   );

   always_comb begin
      case (ctrl.src)
         SRC_HEAD:  out_byte = head_ff;
         SRC_ESC:   out_byte = esc_ff;
         SRC_DATA:  out_byte = data_byte;
         SRC_XDATA: out_byte = data_byte ^ mask_ff;
         SRC_SUM:   out_byte = sum_ff;
         default:   out_byte = head_ff;
      endcase
      if (den_nonpos_ff) begin
         ppm_in = ppm_ff;
      end else if (num_neg_ff) begin
         ppm_in = '0;
      end else begin
         ppm_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= SCALE_W'(2000);
         margin_ff     <= 8'd2;
         head_ff       <= 8'h02;
         esc_ff        <= 8'h7D;
         mask_ff       <= 8'h20;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FULL_SCALE:  full_scale_ff <= csr_data;
            REG_EDGE_MARGIN: margin_ff     <= csr_data[7:0];
            REG_HEAD_BYTE:   head_ff       <= csr_data[7:0];
            REG_ESCAPE_BYTE: esc_ff        <= csr_data[7:0];
            REG_ESCAPE_MASK: mask_ff       <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff   <= '0;
         rise_ff <= '0;
         fall_ff <= '0;
         low_ff  <= '0;
         high_ff <= '0;
         prev_ff <= 1'b0;
      end else if (accept) begin
         ms_ff <= ms_ff + 1'b1;
         if (level != prev_ff) begin
            if (level) begin
               rise_ff <= ms_ff;
               low_ff  <= ms_ff - fall_ff;
            end else begin
               fall_ff <= ms_ff;
               high_ff <= ms_ff - rise_ff;
            end
         end
         prev_ff <= level;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.calc) begin
         prod_ff       <= prod;
         den_ff        <= den[DEN_W-1:0];
         num_neg_ff    <= num[TW];
         den_nonpos_ff <= den[DENX_W-1] || (den == '0);
      end
      if (reset) begin
         ppm_ff <= PPM_W'(1000);
      end else if (ctrl.ppm_load) begin
         ppm_ff <= ppm_in;
      end
      if (ctrl.ppm_load) begin
         sum_ff <= '0;
      end else if (fire && ctrl.src != SRC_HEAD && ctrl.src != SRC_SUM) begin
         sum_ff <= sum_ff + out_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff <= out_byte;
         out_last_ff <= ctrl.last;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

// ===== sim/tb.sv =====
// testbench for the pwm gas sensor framer: pin samples in, predicted frame bytes checked out
`timescale 1ns / 100ps

module tb;
   import pgsdf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;

   typedef struct {
      logic [7:0] frame_byte;
      logic       frame_end;
   } frame_entry_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // [0] pin_level
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;        // [7:0] frame_byte
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow copy of the registers and the decoder state
   logic [13:0] cfg_full_scale = 14'd2000;
   logic [7:0]  cfg_margin = 8'd2;
   logic [7:0]  cfg_head = 8'h02;
   logic [7:0]  cfg_escape = 8'h7D;
   logic [7:0]  cfg_mask = 8'h20;
   logic [31:0] ms_now = '0;
   logic [31:0] rise_at = '0;
   logic [31:0] fall_at = '0;
   logic [31:0] low_len = '0;
   logic        last_level = 1'b0;
   logic [15:0] ppm_val = 16'd1000;

   frame_entry_type frame_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_reqs = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int stuck = 0;

   pwm_gas_sensor_decode_framer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void track_pin(input logic lvl);
      logic [31:0] high_len;
      logic [7:0]  part;
      logic [7:0]  sent;
      logic [7:0]  sum;
      longint      h, lo, m, fs, num, den, q;
      if (lvl != last_level) begin
         if (lvl) begin
            rise_at = ms_now;
            low_len = ms_now - fall_at;
         end else begin
            fall_at = ms_now;
            high_len = ms_now - rise_at;
            h = longint'(high_len);
            lo = longint'(low_len);
            m = longint'(cfg_margin);
            fs = longint'(cfg_full_scale);
            num = h - m;
            den = h + lo - 2 * m;
            if (den > 0) begin
               if (num < 0) begin
                  ppm_val = '0;
               end else begin
                  q = fs * num / den;
                  ppm_val = (q > 65535) ? 16'hFFFF : q[15:0];
               end
            end
            sum = '0;
            frame_q.push_back('{cfg_head, 1'b0});
            for (int i = 0; i < 2; i++) begin
               part = (i == 0) ? ppm_val[15:8] : ppm_val[7:0];
               if (part == cfg_escape || part == cfg_head) begin
                  sent = part ^ cfg_mask;
                  frame_q.push_back('{cfg_escape, 1'b0});
                  frame_q.push_back('{sent, 1'b0});
                  sum = sum + cfg_escape + sent;
               end else begin
                  frame_q.push_back('{part, 1'b0});
                  sum = sum + part;
               end
            end
            frame_q.push_back('{sum, 1'b1});
         end
         last_level = lvl;
      end
      ms_now = ms_now + 1;
   endfunction

   // receiver side: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_reqs != hold_taken) begin
         hold_left = HOLD_CYCLES;
         hold_taken = hold_reqs;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_q.size() == 0) begin
            $error("unexpected transaction: frame_byte %0h frame_end %0b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            if (rsp_tdata !== frame_q[0].frame_byte) begin
               $error("frame_byte: expected %0h, actual %0h", frame_q[0].frame_byte, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== frame_q[0].frame_end) begin
               $error("frame_end: expected %0b, actual %0b", frame_q[0].frame_end, rsp_tlast);
               errors++;
            end
            void'(frame_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stuck = 0;
      else
         stuck++;
      if (stuck >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_sample(input logic lvl);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, lvl};
      do @(posedge clock); while (!req_tready);
      track_pin(lvl);
      @(negedge clock);
   endtask

   task automatic send_run(input logic lvl, input int n);
      repeat (n) send_sample(lvl);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [13:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FULL_SCALE:  cfg_full_scale = val;
         REG_EDGE_MARGIN: cfg_margin = val[7:0];
         REG_HEAD_BYTE:   cfg_head = val[7:0];
         REG_ESCAPE_BYTE: cfg_escape = val[7:0];
         REG_ESCAPE_MASK: cfg_mask = val[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic [13:0] fs, input logic [7:0] margin,
                             input logic [7:0] head, input logic [7:0] esc,
                             input logic [7:0] mask);
      wait_idle();
      write_reg(REG_FULL_SCALE, fs);
      write_reg(REG_EDGE_MARGIN, {6'b0, margin});
      write_reg(REG_HEAD_BYTE, {6'b0, head});
      write_reg(REG_ESCAPE_BYTE, {6'b0, esc});
      write_reg(REG_ESCAPE_MASK, {6'b0, mask});
      csr_valid <= 1'b0;
   endtask

   task automatic random_config();
      logic [13:0] fs;
      logic [7:0]  margin, head, esc;
      case ($urandom_range(3))
         0: fs = 14'd10000;
         1: fs = 14'h3FFF;
         2: fs = 14'($urandom_range(1, 10000));
         default: fs = 14'($urandom_range(0, 16383));
      endcase
      margin = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255)) :
                                          8'($urandom_range(0, 4));
      case ($urandom_range(2))
         0: head = 8'h00;
         1: head = ppm_val[15:8];
         default: head = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(3))
         0: esc = 8'hFF;
         1: esc = ppm_val[7:0];
         2: esc = head;
         default: esc = 8'($urandom_range(0, 255));
      endcase
      set_config(fs, margin, head, esc, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_reset_defaults();
      // low phase of zero length, then a zero denominator keeps ppm
      send_run(1'b1, 4);
      send_run(1'b0, 3);
      send_run(1'b1, 5);
      send_run(1'b0, 1);
   endtask

   task automatic test_ppm_limits();
      set_config(14'h3FFF, 8'd5, 8'h02, 8'h7D, 8'h20);
      // saturation, then unchanged by a negative denominator
      send_run(1'b1, 10);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      send_run(1'b0, 9);
      // negative numerator
      send_run(1'b1, 2);
      send_run(1'b0, 1);
      set_config(14'd10000, 8'd255, 8'hFF, 8'h00, 8'h55);
      send_run(1'b1, 1);
      send_run(1'b0, 1);
   endtask

   task automatic test_byte_stuffing();
      // ppm 100: high byte matches head, low byte matches escape
      set_config(14'd200, 8'd0, 8'h00, 8'h64, 8'hFF);
      send_run(1'b1, 1);
      send_run(1'b0, 1);
      // head equal to escape
      set_config(14'd200, 8'd0, 8'h64, 8'h64, 8'h00);
      send_run(1'b1, 1);
      send_run(1'b0, 1);
      set_config(14'd0, 8'd0, 8'h00, 8'h00, 8'h20);
      send_run(1'b1, 1);
      send_run(1'b0, 1);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
      int   sent;
      int   len;
      logic lvl;
      random_config();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      lvl = ~last_level;
      while (sent < n) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
         send_run(lvl, len);
         sent += len;
         lvl = ~lvl;
      end
   endtask

   task automatic test_output_hold();
      logic lvl;
      random_config();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_reqs++;
      lvl = ~last_level;
      repeat (20) begin
         send_run(lvl, $urandom_range(1, 2));
         lvl = ~lvl;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 30;
      recv_stall_pct = 30;
      test_reset_defaults();
      test_ppm_limits();
      test_byte_stuffing();
      test_random_traffic(0, 0, 6);
      test_random_traffic(0, 0, 6);
      test_random_traffic(76, 0, 6);
      test_random_traffic(76, 0, 6);
      test_random_traffic(0, 76, 6);
      test_random_traffic(0, 76, 6);
      test_random_traffic(15, 15, 6);
      test_random_traffic(15, 15, 6);
      test_output_hold();
      req_tvalid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && frame_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
